[hw/rtl/cfur_pkg.sv]
// ----------------------------------------------------------------------------
// cfur_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the framed
// update receiver.
// ----------------------------------------------------------------------------
package cfur_pkg;

	localparam int unsigned MAX_PAYLOAD = 128;

	localparam logic [7:0]  HDR_FIRST  = 8'h55;
	localparam logic [7:0]  HDR_SECOND = 8'hAA;
	localparam logic [7:0]  REPLY_ACK  = 8'h06;
	localparam logic [7:0]  REPLY_NACK = 8'h07;
	localparam logic [7:0]  REPLY_NONE = 8'h00;

	localparam logic [7:0]  OPC_START    = 8'h00;
	localparam logic [7:0]  OPC_COMPLETE = 8'h01;
	localparam logic [7:0]  OPC_WRITE    = 8'h02;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int unsigned OUT_TDATA_W = 72;
	localparam int unsigned OUT_TUSER_W = 2;

	typedef enum logic [1:0] {
		EV_PAYLOAD  = 2'd0,
		EV_ACK      = 2'd1,
		EV_NACK     = 2'd2,
		EV_NO_REPLY = 2'd3
	} event_kind_t;

	typedef enum logic [6:0] {
		PH_HEAD1 = 7'b0000001,
		PH_HEAD2 = 7'b0000010,
		PH_LEN   = 7'b0000100,
		PH_CMD   = 7'b0001000,
		PH_DATA  = 7'b0010000,
		PH_CRCLO = 7'b0100000,
		PH_CRCHI = 7'b1000000
	} phase_t;

	// Reflected CRC-16, one byte: eight shift/xor steps on 16 bits.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/crc16_framed_update_receiver.sv]
// ----------------------------------------------------------------------------
// crc16_framed_update_receiver
// Parses 0x55 0xAA framed update packets byte by byte, checks CRC-16/MODBUS,
// forwards payload bytes as tentative flash writes and reports frame outcome.
// ----------------------------------------------------------------------------
// Output timing: a result word is registered and appears on the master side in the
// cycle after the input word that causes it is accepted.
// Throughput: one input word per cycle; the parser state and the output
// register both update in the accepting cycle, so only output stall slows it.
// Reset: arst_n clears the parser to header hunt, CRC to 0xFFFF, write
// pointer and base address to zero, and empties the output register.
module crc16_framed_update_receiver
	import cfur_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: download_base_addr
	input  logic                   cfg_wr_en,
	input  logic [31:0]            cfg_wr_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] rx_byte
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] data_byte, [39:8] flash_addr, [47:40] reply_byte,
	// [55:48] command_code, [56] erase_request, [57] commit_write,
	// [58] update_request, [66:59] frame_length, [71:67] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [OUT_TUSER_W-1:0] m_tuser    // [1:0] event_kind
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	phase_t      phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  seen_q, seen_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [31:0] wptr_q, wptr_d;
	logic [31:0] base_q;

	logic        res_valid;
	event_kind_t res_kind;
	logic [7:0]  res_data;
	logic [31:0] res_addr;
	logic [7:0]  res_reply;
	logic [7:0]  res_cmd;
	logic        res_erase, res_commit, res_update;
	logic [7:0]  res_len;

	logic        accept;
	logic [15:0] crc_next;
	logic [15:0] crc_got;
	logic [7:0]  seen_inc;

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign crc_next = crc16_byte((phase_q == PH_LEN) ? CRC_INIT : crc_q, s_tdata);
	assign crc_got  = {s_tdata, crc_lo_q};
	assign seen_inc = seen_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		len_d      = len_q;
		cmd_d      = cmd_q;
		seen_d     = seen_q;
		crc_d      = crc_q;
		crc_lo_d   = crc_lo_q;
		wptr_d     = wptr_q;
		res_valid  = 1'b0;
		res_kind   = EV_PAYLOAD;
		res_data   = 8'h00;
		res_addr   = wptr_q;
		res_reply  = REPLY_NONE;
		res_cmd    = cmd_q;
		res_erase  = 1'b0;
		res_commit = 1'b0;
		res_update = 1'b0;
		res_len    = len_q;
		case (phase_q)
			PH_HEAD1: begin
				phase_d = (s_tdata == HDR_FIRST) ? PH_HEAD2 : PH_HEAD1;
			end
			PH_HEAD2: begin
				if (s_tdata == HDR_SECOND) begin
					phase_d = PH_LEN;
				end else if (s_tdata != HDR_FIRST) begin
					phase_d = PH_HEAD1;
				end
			end
			PH_LEN: begin
				// drop oversize frames and restart the hunt
				if (s_tdata > MAX_LEN) begin
					phase_d = PH_HEAD1;
				end else begin
					len_d   = s_tdata;
					seen_d  = 8'd0;
					crc_d   = crc_next;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_d   = s_tdata;
				crc_d   = crc_next;
				phase_d = (len_q == 8'd0) ? PH_CRCLO : PH_DATA;
			end
			PH_DATA: begin
				crc_d     = crc_next;
				res_valid = 1'b1;
				res_kind  = EV_PAYLOAD;
				res_data  = s_tdata;
				res_addr  = wptr_q + {24'd0, seen_q};
				res_cmd   = 8'h00;
				res_len   = 8'h00;
				seen_d    = seen_inc;
				if (seen_inc >= len_q) begin
					phase_d = PH_CRCLO;
				end
			end
			PH_CRCLO: begin
				crc_lo_d = s_tdata;
				phase_d  = PH_CRCHI;
			end
			PH_CRCHI: begin
				phase_d   = PH_HEAD1;
				res_valid = 1'b1;
				if (crc_got != crc_q) begin
					res_kind  = EV_NACK;
					res_reply = REPLY_NACK;
				end else begin
					case (cmd_q)
						OPC_START: begin
							wptr_d    = base_q;
							res_addr  = base_q;
							res_kind  = EV_ACK;
							res_reply = REPLY_ACK;
							res_erase = 1'b1;
						end
						OPC_COMPLETE: begin
							res_kind   = EV_ACK;
							res_reply  = REPLY_ACK;
							res_update = 1'b1;
						end
						OPC_WRITE: begin
							wptr_d     = wptr_q + {24'd0, len_q};
							res_kind   = EV_ACK;
							res_reply  = REPLY_ACK;
							res_commit = 1'b1;
						end
						default: begin
							res_kind = EV_NO_REPLY;
						end
					endcase
				end
			end
			default: begin
				phase_d = PH_HEAD1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD1;
			len_q    <= 8'd0;
			cmd_q    <= 8'd0;
			seen_q   <= 8'd0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= 8'd0;
			wptr_q   <= 32'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			cmd_q    <= cmd_d;
			seen_q   <= seen_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			wptr_q   <= wptr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// output register: load on accept, clear valid once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= res_valid;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			m_tuser <= res_kind;
			m_tdata <= {5'd0, res_len, res_update, res_commit, res_erase,
				res_cmd, res_reply, res_addr, res_data};
		end
	end

	a_data_gives_payload: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_DATA |=> m_tvalid && m_tuser == EV_PAYLOAD)
		else $error("payload byte did not produce a payload word");

	a_quiet_phases: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (phase_q == PH_HEAD1 || phase_q == PH_HEAD2 || phase_q == PH_LEN ||
			phase_q == PH_CMD || phase_q == PH_CRCLO) |=> !m_tvalid)
		else $error("result word produced outside payload or frame end");

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> seen_q < len_q)
		else $error("payload count ran past frame length");

	a_request_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[56] || m_tdata[57] || m_tdata[58]) |->
			m_tuser == EV_ACK && m_tdata[47:40] == REPLY_ACK)
		else $error("flash request raised without ACK");

endmodule
